// ----- hw/rtl/dq_pkg.sv -----
package dq_pkg;

    // Queue geometry
    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the word interface
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 11;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_FRONT = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_BACK  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Answer for pushes and for reads of an empty queue
    localparam logic signed [VAL_W-1:0] EMPTY_WORD = -32'sd1;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] store_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] data_out;
        logic [STAT_W-1:0]       status;
        logic [OCC_W-1:0]        occupancy;
        logic                    is_empty;
    } rsp_t;

    function automatic addr_t idx_next(addr_t i);
        return (i == ADDR_W'(DEPTH - 1)) ? '0 : addr_t'(i + 1'b1);
    endfunction

    function automatic addr_t idx_prev(addr_t i);
        return (i == '0) ? ADDR_W'(DEPTH - 1) : addr_t'(i - 1'b1);
    endfunction

    // Keep the low DATA_WIDTH bits of the sign-extended input word
    function automatic store_t to_word(logic signed [VAL_W-1:0] v);
        logic signed [DATA_WIDTH-1:0] w;
        w = DATA_WIDTH'(v);
        return store_t'(w);
    endfunction

    // Sign-extend a stored word and keep the low 32 bits
    function automatic logic signed [VAL_W-1:0] from_word(store_t w);
        logic signed [DATA_WIDTH-1:0] s;
        s = signed'(w);
        return VAL_W'(s);
    endfunction

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
// double_ended_queue: double-ended queue of signed 32-bit words in a ring buffer.
//
// Command channel (cmd_valid / cmd_stall / cmd): one word carries an op and a
// value. Ops push or pop at either end, or read either end without removing.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one word per command,
// in command order, with the read value (-1 for pushes and empty reads), a
// status (ok, empty, full), the occupancy after the op and an empty flag.
//
// The accepting edge moves the pointers and does the storage access, whose read
// data lands in the registered RAM output; the response register loads it when
// it is free or draining. Throughput is one command per cycle while the receiver
// does not stall: pointers advance at accept, so the next command issues its
// access while the previous one collects its read data. The single-port storage
// RAM sets that figure.
//
// Reset clears the pointers and the count; storage contents are not cleared
// and need no clearing pass, so the queue accepts commands right after reset.
// When the receiver stalls, the response register holds, the finishing command
// waits behind it with its read data held in the RAM output, and cmd_stall
// rises until the response drains.
module double_ended_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    output logic         cmd_stall,
    input  dq_pkg::cmd_t cmd,
    output logic         rsp_valid,
    input  logic         rsp_stall,
    output dq_pkg::rsp_t rsp
);

    import dq_pkg::*;

    // Ring pointers and fill count
    addr_t head_reg, head_next;
    addr_t tail_reg, tail_next;
    cnt_t  count_reg, count_next;

    // Command in flight, waiting on RAM read data
    logic              busy_reg;
    logic              pend_rd_reg,  pend_rd_next;
    logic [STAT_W-1:0] pend_stat_reg, pend_stat_next;
    cnt_t              pend_cnt_reg;

    // Response register
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    // Storage RAM port
    logic   ram_en, ram_we;
    addr_t  ram_addr;
    store_t ram_rdata;

    logic accept, done, full, empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Finish the in-flight command when the response register is free or draining
    assign done      = busy_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = busy_reg && !done;
    assign accept    = cmd_valid && !cmd_stall;

    // Decode the op: move pointers and pick the storage access
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        pend_rd_next   = 1'b0;
        pend_stat_next = ST_OK;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = head_reg;
        unique case (cmd.op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                begin
                    pend_stat_next = ST_FULL;
                end
                else
                begin
                    ram_en     = 1'b1;
                    ram_we     = 1'b1;
                    count_next = cnt_t'(count_reg + 1'b1);
                    if (cmd.op == OP_PUSH_FRONT)
                    begin
                        head_next = idx_prev(head_reg);
                        ram_addr  = idx_prev(head_reg);
                    end
                    else
                    begin
                        tail_next = idx_next(tail_reg);
                        ram_addr  = tail_reg;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK:
            begin
                if (empty)
                begin
                    pend_stat_next = ST_EMPTY;
                end
                else
                begin
                    ram_en       = 1'b1;
                    pend_rd_next = 1'b1;
                    unique case (cmd.op)
                        OP_POP_FRONT:
                        begin
                            ram_addr   = head_reg;
                            head_next  = idx_next(head_reg);
                            count_next = cnt_t'(count_reg - 1'b1);
                        end
                        OP_POP_BACK:
                        begin
                            ram_addr   = idx_prev(tail_reg);
                            tail_next  = idx_prev(tail_reg);
                            count_next = cnt_t'(count_reg - 1'b1);
                        end
                        OP_READ_FRONT:
                        begin
                            ram_addr = head_reg;
                        end
                        default:
                        begin
                            ram_addr = idx_prev(tail_reg);
                        end
                    endcase
                end
            end
            default:
            begin
                // Unused codes: no change
            end
        endcase
        // Drop the access unless the command is actually taken
        ram_en = ram_en && accept;
    end

    dq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (to_word(cmd.value)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            pend_rd_reg   <= 1'b0;
            pend_stat_reg <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Advance pointers and capture the pending result on accept
            if (accept)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                pend_rd_reg   <= pend_rd_next;
                pend_stat_reg <= pend_stat_next;
                busy_reg      <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (done)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_cnt_reg <= count_next;
        end
        if (done)
        begin
            rsp_reg.data_out  <= pend_rd_reg ? from_word(ram_rdata) : EMPTY_WORD;
            rsp_reg.status    <= pend_stat_reg;
            rsp_reg.occupancy <= OCC_W'(pend_cnt_reg);
            rsp_reg.is_empty  <= (pend_cnt_reg == '0);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Fill count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count exceeds capacity");

    // Empty flag agrees with occupancy
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.is_empty == (rsp_reg.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    // Empty status answers -1 on an empty queue
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status == ST_EMPTY)
            |-> (rsp_reg.is_empty && rsp_reg.data_out == EMPTY_WORD))
        else $error("empty status with data or nonzero occupancy");

    // A pending command waits while the response is stalled
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && rsp_valid_reg && rsp_stall) |=> busy_reg)
        else $error("pending command lost behind stalled response");

endmodule

// ----- hw/rtl/dq_ram.sv -----
module dq_ram #(
    parameter int DEPTH_P = 1024,
    parameter int WIDTH_P = 32
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic                                      we,
    input  logic [((DEPTH_P > 1) ? $clog2(DEPTH_P) : 1)-1:0] addr,
    input  logic [WIDTH_P-1:0]                        wdata,
    output logic [WIDTH_P-1:0]                        rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    // Single port, read data registered; hold rdata when idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- bench/deque_checker.sv -----
module deque_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cmd_valid,
    input  logic         cmd_stall,
    input  dq_pkg::cmd_t cmd,
    input  logic         rsp_valid,
    input  logic         rsp_stall,
    input  dq_pkg::rsp_t rsp,
    output int           mismatches,
    output int           outstanding,
    output int           full_drops,
    output int           empty_hits,
    output int           peak_fill
);

    import dq_pkg::*;

    // Shadow copy of the ring buffer
    store_t slots [DEPTH];
    int     front_slot;
    int     back_slot;
    int     fill;

    rsp_t   awaited_answers [$];
    int     failures = 0;
    int     answers_seen;

    assign mismatches = failures;

    task automatic note_failure(string what);
        $display("[%0t] mismatch: %s", $time, what);
        failures++;
    endtask

    // Keep the low DATA_WIDTH bits of a sign-extended input word
    function automatic store_t word_to_slot(logic signed [VAL_W-1:0] v);
        longint wide;
        wide = longint'(v);
        return store_t'(wide);
    endfunction

    // Sign-extend a stored word and keep 32 bits of it
    function automatic logic signed [VAL_W-1:0] slot_to_word(store_t w);
        logic signed [DATA_WIDTH-1:0] s;
        longint                       wide;
        s    = signed'(w);
        wide = longint'(s);
        return wide[VAL_W-1:0];
    endfunction

    // Apply one command word to the shadow queue and return the answer it earns
    function automatic rsp_t predict_deque_answer(cmd_t c);
        rsp_t a;
        a.data_out = EMPTY_WORD;
        a.status   = ST_OK;
        case (c.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                begin
                    a.status = ST_FULL;
                    full_drops++;
                end
                else if (c.op == OP_PUSH_FRONT)
                begin
                    front_slot        = (front_slot + DEPTH - 1) % DEPTH;
                    slots[front_slot] = word_to_slot(c.value);
                    fill++;
                end
                else
                begin
                    slots[back_slot] = word_to_slot(c.value);
                    back_slot        = (back_slot + 1) % DEPTH;
                    fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK:
            begin
                if (fill == 0)
                begin
                    a.status = ST_EMPTY;
                    empty_hits++;
                end
                else if (c.op == OP_POP_FRONT)
                begin
                    a.data_out = slot_to_word(slots[front_slot]);
                    front_slot = (front_slot + 1) % DEPTH;
                    fill--;
                end
                else if (c.op == OP_POP_BACK)
                begin
                    back_slot  = (back_slot + DEPTH - 1) % DEPTH;
                    a.data_out = slot_to_word(slots[back_slot]);
                    fill--;
                end
                else if (c.op == OP_READ_FRONT)
                begin
                    a.data_out = slot_to_word(slots[front_slot]);
                end
                else
                begin
                    a.data_out = slot_to_word(slots[(back_slot + DEPTH - 1) % DEPTH]);
                end
            end
            default:
            begin
            end
        endcase
        a.occupancy = OCC_W'(fill);
        a.is_empty  = (fill == 0);
        if (fill > peak_fill)
        begin
            peak_fill = fill;
        end
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            front_slot   = 0;
            back_slot    = 0;
            fill         = 0;
            full_drops   = 0;
            empty_hits   = 0;
            peak_fill    = 0;
            answers_seen = 0;
            awaited_answers.delete();
            outstanding <= 0;
        end
        else
        begin
            // Check the answer first so a stray word never meets this edge's prediction
            if (rsp_valid && !rsp_stall)
            begin
                answers_seen++;
                if (awaited_answers.size() == 0)
                begin
                    note_failure($sformatf("answer %0d arrived with none outstanding",
                                           answers_seen));
                end
                else
                begin
                    want = awaited_answers[0];
                    awaited_answers.delete(0);
                    if (rsp.data_out !== want.data_out)
                        note_failure($sformatf("answer %0d data_out %08h, want %08h",
                                               answers_seen, rsp.data_out, want.data_out));
                    if (rsp.status !== want.status)
                        note_failure($sformatf("answer %0d status %0d, want %0d",
                                               answers_seen, rsp.status, want.status));
                    if (rsp.occupancy !== want.occupancy)
                        note_failure($sformatf("answer %0d occupancy %0d, want %0d",
                                               answers_seen, rsp.occupancy, want.occupancy));
                    if (rsp.is_empty !== want.is_empty)
                        note_failure($sformatf("answer %0d is_empty %0b, want %0b",
                                               answers_seen, rsp.is_empty, want.is_empty));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                awaited_answers.insert(awaited_answers.size(), predict_deque_answer(cmd));
            end
            outstanding <= awaited_answers.size();
        end
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    import dq_pkg::*;

    // Op codes the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // Extra pushes past capacity and extra pops past empty in the sweep
    localparam int OVERRUN = 8;

    // Length of the receiver hold-off that backs the block up into its input
    localparam int BACKLOG_CYCLES = 300;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    cmd_t cmd       = '0;
    logic rsp_stall = 1'b0;
    logic cmd_stall;
    logic rsp_valid;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    int full_drops;
    int empty_hits;
    int peak_fill;

    // Counters of accepted words by kind, for the closing summary
    int n_push  = 0;
    int n_pop   = 0;
    int n_read  = 0;
    int n_spare = 0;

    // Stimulus asks for a long receiver hold-off by bumping backlog_asks
    int backlog_asks = 0;
    int backlog_done = 0;

    always #6 clk = ~clk;

    double_ended_queue u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    deque_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .full_drops  (full_drops),
        .empty_hits  (empty_hits),
        .peak_fill   (peak_fill)
    );

    // Pick a value: mostly random, sometimes one of the extremes or all-ones/zero
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Sender gap: mostly none or short, now and then long; none at all when calm
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Choose an op: push_pct percent pushes, pop_pct percent pops, rest reads
    // with a sprinkle of the unused codes
    function automatic logic [OP_W-1:0] pick_op(int push_pct, int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return ($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            return ($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
        else if (r >= 98)
            return ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        else
            return ($urandom_range(0, 1) == 0) ? OP_READ_FRONT : OP_READ_BACK;
    endfunction

    // Offer one word after an optional idle gap; hold it until the block takes it.
    // Called at a rising edge and returns at the edge that accepted the word.
    task automatic send_word(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] value, int gap);
        cmd_t w;
        w.op    = op;
        w.value = value;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:                 n_push++;
            OP_POP_FRONT, OP_POP_BACK:                   n_pop++;
            OP_READ_FRONT, OP_READ_BACK:                 n_read++;
            default:                                     n_spare++;
        endcase
    endtask

    // Drop valid and wait until every word sent so far has been answered
    task automatic drain_answers();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, calm stretches, and the long hold-off on request.
    // Exactly one assignment to rsp_stall per edge.
    initial
    begin
        int hold_left;
        int calm_left;
        int r;
        hold_left = 0;
        calm_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else if (backlog_asks != backlog_done)
            begin
                // Long hold-off: the block fills and must push back on the sender
                backlog_done <= backlog_asks;
                hold_left = BACKLOG_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (calm_left > 0)
            begin
                rsp_stall <= 1'b0;
                calm_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    calm_left = $urandom_range(20, 80);
                    rsp_stall <= 1'b0;
                end
                else if (r < 60)
                begin
                    rsp_stall <= 1'b0;
                end
                else if (r < 95)
                begin
                    hold_left = $urandom_range(0, 3);
                    rsp_stall <= 1'b1;
                end
                else
                begin
                    hold_left = $urandom_range(10, 40);
                    rsp_stall <= 1'b1;
                end
            end
        end
    end

    // Ceiling on the whole run
    initial
    begin
        #(12 * 2_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int  push_mix [4];
        int  pushes_sent;
        int  pops_sent;
        bit  calm;
        logic [OP_W-1:0] op;

        push_mix = '{50, 75, 25, 50};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-queue answers, unused codes, extreme values, both ends,
        // front index wrapping below zero, and popping back to empty
        send_word(OP_READ_FRONT, 32'sd0, 0);
        send_word(OP_READ_BACK,  32'sd0, 0);
        send_word(OP_POP_FRONT,  32'sd0, 0);
        send_word(OP_POP_BACK,   32'sd0, 0);
        send_word(OP_SPARE_LO,   32'sh7FFF_FFFF, 0);
        send_word(OP_SPARE_HI,   32'sh8000_0000, 0);
        send_word(OP_PUSH_FRONT, 32'sh7FFF_FFFF, 0);
        send_word(OP_PUSH_BACK,  32'sh8000_0000, 0);
        send_word(OP_READ_FRONT, 32'sd0, 0);
        send_word(OP_READ_BACK,  32'sd0, 0);
        send_word(OP_PUSH_FRONT, 32'sh0000_0000, 0);
        send_word(OP_PUSH_BACK,  32'shFFFF_FFFF, 0);
        send_word(OP_PUSH_FRONT, 32'sh5555_5555, 1);
        send_word(OP_PUSH_BACK,  32'shAAAA_AAAA, 0);
        send_word(OP_SPARE_LO,   32'sh1234_5678, 0);
        send_word(OP_POP_BACK,   32'sd0, 0);
        send_word(OP_POP_FRONT,  32'sd0, 2);
        send_word(OP_READ_FRONT, 32'sd0, 0);
        send_word(OP_READ_BACK,  32'sd0, 0);
        send_word(OP_POP_BACK,   32'sd0, 0);
        send_word(OP_POP_FRONT,  32'sd0, 0);
        send_word(OP_POP_FRONT,  32'sd0, 0);
        send_word(OP_POP_BACK,   32'sd0, 0);
        send_word(OP_READ_BACK,  32'sd0, 0);

        // Mixed traffic at several push/pop balances; every third segment runs calm
        for (int seg = 0; seg < 4; seg++)
        begin
            calm = (seg % 3 == 2);
            for (int i = 0; i < 75; i++)
                send_word(pick_op(push_mix[seg], 90 - push_mix[seg]), pick_value(),
                          pick_gap(calm));
        end

        // Back up the block: hold the receiver off while words keep coming
        backlog_asks <= backlog_asks + 1;
        for (int i = 0; i < 48; i++)
            send_word(pick_op(60, 30), pick_value(), 0);

        // Pause the sender until every answer is in
        drain_answers();

        // Fill past capacity so pushes get dropped, with a few reads mixed in
        pushes_sent = 0;
        while (pushes_sent < DEPTH + OVERRUN)
        begin
            op = pick_op(97, 0);
            if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
                pushes_sent++;
            send_word(op, pick_value(), pick_gap(1'b0));
        end

        // Drain past empty from both ends
        pops_sent = 0;
        while (pops_sent < DEPTH + OVERRUN)
        begin
            op = pick_op(0, 97);
            if (op == OP_POP_FRONT || op == OP_POP_BACK)
                pops_sent++;
            send_word(op, pick_value(), pick_gap(1'b0));
        end

        // Wait out the last answers, then wait on to catch any stray words
        drain_answers();
        repeat (8) @(posedge clk);

        $display("covered %0d words: %0d pushes, %0d pops, %0d reads, %0d unused codes",
                 n_push + n_pop + n_read + n_spare, n_push, n_pop, n_read, n_spare);
        $display("pushes dropped on full %0d, empty answers %0d, peak occupancy %0d",
                 full_drops, empty_hits, peak_fill);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/double_ended_queue.sv
bench/deque_checker.sv
bench/tb.sv
